### hw/rtl/cst_pkg.sv
`timescale 1ns / 1ps

package cst_pkg;

  // default configuration
  localparam int IDENT_MAX_DEF = 8;
  localparam int POS_BITS_DEF  = 16;

  // fixed field widths of the channels
  localparam int CH_W    = 8;
  localparam int KIND_W  = 4;
  localparam int VALUE_W = 32;
  localparam int TEXT_W  = 64;
  localparam int LEN_W   = 4;
  localparam int POS_W   = 16;

  // result queue between scanner and output port
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // keyword spellings, first byte in the lowest byte
  localparam logic [47:0] KW_INT_TEXT    = 48'h0000_0074_6E69;
  localparam logic [47:0] KW_RETURN_TEXT = 48'h6E72_7574_6572;

  typedef enum logic [KIND_W-1:0] {
    KIND_EOF       = 4'd0,
    KIND_IDENT     = 4'd1,
    KIND_KW_INT    = 4'd2,
    KIND_KW_RETURN = 4'd3,
    KIND_NUMBER    = 4'd4,
    KIND_LPAREN    = 4'd5,
    KIND_RPAREN    = 4'd6,
    KIND_LBRACK    = 4'd7,
    KIND_RBRACK    = 4'd8,
    KIND_LBRACE    = 4'd9,
    KIND_RBRACE    = 4'd10,
    KIND_SEMI      = 4'd11,
    KIND_ERROR     = 4'd12
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [VALUE_W-1:0]  int_value;
    logic [TEXT_W-1:0]   ident_text;
    logic [LEN_W-1:0]    ident_len;
    logic                ident_overflow;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                last;
  } result_t;

  // up to two tokens produced by one source byte
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hw/rtl/cst_if.sv
`timescale 1ns / 1ps

interface cst_in_if;
  logic                     valid;
  logic                     ready;
  logic [cst_pkg::CH_W-1:0] ch;
  logic                     end_of_input;

  modport source (output valid, output ch, output end_of_input, input ready);
  modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface cst_out_if;
  logic                        valid;
  logic                        ready;
  cst_pkg::kind_t              kind;
  logic [cst_pkg::VALUE_W-1:0] int_value;
  logic [cst_pkg::TEXT_W-1:0]  ident_text;
  logic [cst_pkg::LEN_W-1:0]   ident_len;
  logic                        ident_overflow;
  logic [cst_pkg::POS_W-1:0]   row;
  logic [cst_pkg::POS_W-1:0]   col;
  logic                        last;

  modport source (output valid, output kind, output int_value, output ident_text,
                  output ident_len, output ident_overflow, output row, output col,
                  output last, input ready);
  modport sink   (input valid, input kind, input int_value, input ident_text,
                  input ident_len, input ident_overflow, input row, input col,
                  input last, output ready);
endinterface

### hw/rtl/cst_scan.sv
`timescale 1ns / 1ps

module cst_scan #(
  parameter int IDENT_MAX = cst_pkg::IDENT_MAX_DEF,
  parameter int POS_BITS  = cst_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  cst_in_if.sink          in_bus,
  input  logic            push_ok,
  output cst_pkg::push_t  push
);

  localparam int BUF_W = IDENT_MAX * 8;
  localparam int CNT_W = $clog2(IDENT_MAX + 1);
  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_IDENT  = 2'd1,
    MODE_NUMBER = 2'd2
  } mode_t;

  // input stage
  logic                     stg_vld_r;
  logic [cst_pkg::CH_W-1:0] ch_r;
  logic                     eoi_r;
  logic                     stg_go;

  // lexer state
  mode_t                mode_r, mode_nxt;
  logic [BUF_W-1:0]     buf_r, buf_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 too_long_r, too_long_nxt;
  logic [31:0]          accum_r, accum_nxt;
  logic [POS_BITS-1:0]  line_r, line_nxt;
  logic [POS_BITS-1:0]  col_r, col_nxt;
  logic [POS_BITS-1:0]  start_row_r, start_row_nxt;
  logic [POS_BITS-1:0]  start_col_r, start_col_nxt;

  // per-byte decode
  logic                 is_letter, is_digit, is_space, is_nl;
  logic                 cont_ident, cont_num, has_flush, has_second;
  logic [POS_BITS-1:0]  line_adv, col_adv, line_new, col_new;
  logic [31:0]          digit_val;
  logic                 kw_int, kw_return;
  cst_pkg::kind_t       ident_kind, punct_kind;
  cst_pkg::result_t     flush_res, second_res;

  function automatic logic [cst_pkg::POS_W-1:0] to_port(input logic [POS_BITS-1:0] v);
    logic [31:0] wide;
    wide = 32'(v);
    return wide[cst_pkg::POS_W-1:0];
  endfunction

  assign stg_go       = stg_vld_r && push_ok;
  assign in_bus.ready = !stg_vld_r || push_ok;

  // character classes
  always_comb begin
    is_letter = (ch_r >= CH_LO_A && ch_r <= CH_LO_Z) ||
                (ch_r >= CH_UP_A && ch_r <= CH_UP_Z) || ch_r == CH_UNDER;
    is_digit  = ch_r >= CH_ZERO && ch_r <= CH_NINE;
    is_space  = ch_r == CH_SPACE || (ch_r >= CH_TAB && ch_r <= CH_CR);
    is_nl     = ch_r == CH_NL;
    digit_val = 32'(ch_r - CH_ZERO);
  end

  // punctuation lookup
  always_comb begin
    unique case (ch_r)
      CH_LPAREN: punct_kind = cst_pkg::KIND_LPAREN;
      CH_RPAREN: punct_kind = cst_pkg::KIND_RPAREN;
      CH_LBRACK: punct_kind = cst_pkg::KIND_LBRACK;
      CH_RBRACK: punct_kind = cst_pkg::KIND_RBRACK;
      CH_LBRACE: punct_kind = cst_pkg::KIND_LBRACE;
      CH_RBRACE: punct_kind = cst_pkg::KIND_RBRACE;
      CH_SEMI:   punct_kind = cst_pkg::KIND_SEMI;
      default:   punct_kind = cst_pkg::KIND_ERROR;
    endcase
  end

  // saturating position update
  always_comb begin
    line_adv = (line_r == POS_MAX) ? line_r : line_r + POS_BITS'(1);
    col_adv  = (col_r == POS_MAX) ? col_r : col_r + POS_BITS'(1);
    line_new = is_nl ? line_adv : line_r;
    col_new  = is_nl ? '0 : col_adv;
  end

  // token boundary decisions
  always_comb begin
    cont_ident = !eoi_r && mode_r == MODE_IDENT && (is_letter || is_digit);
    cont_num   = !eoi_r && mode_r == MODE_NUMBER && is_digit;
    has_flush  = mode_r != MODE_IDLE && !cont_ident && !cont_num;
    has_second = eoi_r ||
                 (!cont_ident && !cont_num && !is_letter && !is_digit && !is_space);
    kw_int     = !too_long_r && cnt_r == CNT_W'(3) && buf_r == BUF_W'(cst_pkg::KW_INT_TEXT);
    kw_return  = !too_long_r && cnt_r == CNT_W'(6) &&
                 buf_r == BUF_W'(cst_pkg::KW_RETURN_TEXT);
    ident_kind = kw_int ? cst_pkg::KIND_KW_INT :
                 kw_return ? cst_pkg::KIND_KW_RETURN : cst_pkg::KIND_IDENT;
  end

  // pending token result
  always_comb begin
    flush_res     = '0;
    flush_res.row = to_port(start_row_r);
    flush_res.col = to_port(start_col_r);
    if (mode_r == MODE_NUMBER) begin
      flush_res.kind      = cst_pkg::KIND_NUMBER;
      flush_res.int_value = accum_r;
    end else begin
      flush_res.kind = ident_kind;
      if (ident_kind == cst_pkg::KIND_IDENT) begin
        flush_res.ident_text     = cst_pkg::TEXT_W'(buf_r);
        flush_res.ident_len      = cst_pkg::LEN_W'(cnt_r);
        flush_res.ident_overflow = too_long_r;
      end
    end
  end

  // eof or single-byte token result
  always_comb begin
    second_res      = '0;
    second_res.last = 1'b1;
    if (eoi_r) begin
      second_res.kind = cst_pkg::KIND_EOF;
      second_res.row  = to_port(line_r);
      second_res.col  = to_port(col_r);
    end else begin
      second_res.kind = punct_kind;
      second_res.row  = to_port(line_new);
      second_res.col  = to_port(col_new);
    end
  end

  // beat toward the result queue
  always_comb begin
    push.count      = stg_go ? (2'(has_flush) + 2'(has_second)) : 2'd0;
    push.first      = has_flush ? flush_res : second_res;
    push.first.last = !(has_flush && has_second);
    push.second     = second_res;
  end

  // next lexer state
  always_comb begin
    mode_nxt      = mode_r;
    buf_nxt       = buf_r;
    cnt_nxt       = cnt_r;
    too_long_nxt  = too_long_r;
    accum_nxt     = accum_r;
    line_nxt      = line_new;
    col_nxt       = col_new;
    start_row_nxt = start_row_r;
    start_col_nxt = start_col_r;
    if (eoi_r) begin
      mode_nxt      = MODE_IDLE;
      buf_nxt       = '0;
      cnt_nxt       = '0;
      too_long_nxt  = 1'b0;
      accum_nxt     = '0;
      line_nxt      = POS_BITS'(1);
      col_nxt       = '0;
      start_row_nxt = POS_BITS'(1);
      start_col_nxt = '0;
    end else if (cont_ident) begin
      if (cnt_r < CNT_W'(IDENT_MAX)) begin
        for (int i = 0; i < IDENT_MAX; i++) begin
          if (cnt_r == CNT_W'(i)) begin
            buf_nxt[i*8 +: 8] = ch_r;
          end
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end else begin
        too_long_nxt = 1'b1;
      end
    end else if (cont_num) begin
      // x*10 as x*8 + x*2
      accum_nxt = {accum_r[28:0], 3'b000} + {accum_r[30:0], 1'b0} + digit_val;
    end else begin
      mode_nxt     = MODE_IDLE;
      buf_nxt      = '0;
      cnt_nxt      = '0;
      too_long_nxt = 1'b0;
      accum_nxt    = '0;
      if (is_letter) begin
        mode_nxt      = MODE_IDENT;
        buf_nxt       = BUF_W'(ch_r);
        cnt_nxt       = CNT_W'(1);
        start_row_nxt = line_new;
        start_col_nxt = col_new;
      end else if (is_digit) begin
        mode_nxt      = MODE_NUMBER;
        accum_nxt     = digit_val;
        start_row_nxt = line_new;
        start_col_nxt = col_new;
      end
    end
  end

  // input stage payload
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      ch_r  <= in_bus.ch;
      eoi_r <= in_bus.end_of_input;
    end
  end

  // input stage valid and lexer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r   <= 1'b0;
      mode_r      <= MODE_IDLE;
      buf_r       <= '0;
      cnt_r       <= '0;
      too_long_r  <= 1'b0;
      accum_r     <= '0;
      line_r      <= POS_BITS'(1);
      col_r       <= '0;
      start_row_r <= POS_BITS'(1);
      start_col_r <= '0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        stg_vld_r <= 1'b1;
      end else if (stg_go) begin
        stg_vld_r <= 1'b0;
      end
      if (stg_go) begin
        mode_r      <= mode_nxt;
        buf_r       <= buf_nxt;
        cnt_r       <= cnt_nxt;
        too_long_r  <= too_long_nxt;
        accum_r     <= accum_nxt;
        line_r      <= line_nxt;
        col_r       <= col_nxt;
        start_row_r <= start_row_nxt;
        start_col_r <= start_col_nxt;
      end
    end
  end

endmodule

### hw/rtl/c_subset_tokenizer.sv
`timescale 1ns / 1ps

// Tokenizer for a small C subset, fed one source byte per beat on in_bus and giving
// one token per beat on out_bus (identifiers, the keywords int and return, decimal
// integers, ( ) [ ] { } ;, error tokens and EOF). A byte enters an input register,
// is classified and folded into the lexer state once the result queue has room for
// two tokens, and the tokens it produces land in a four-entry result queue that
// drives out_bus. A new byte is taken every cycle while that room is there. A byte
// that both ends a pending identifier or number and forms a token of its own gives
// two output beats, so throughput on such bytes is set by the single output port at
// one token per cycle while the receiver is ready. The end-of-input beat flushes any
// pending token, gives EOF with last set and returns the lexer to its reset state.
module c_subset_tokenizer #(
  parameter int IDENT_MAX = cst_pkg::IDENT_MAX_DEF,
  parameter int POS_BITS  = cst_pkg::POS_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cst_in_if.sink     in_bus,
  cst_out_if.source  out_bus
);

  cst_pkg::push_t   push;
  logic             push_ok;

  cst_pkg::result_t              q_mem [cst_pkg::QUEUE_DEPTH];
  logic [cst_pkg::QPTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [cst_pkg::QCNT_W-1:0]    q_cnt_r;
  logic                          pop;
  cst_pkg::result_t              head;

  cst_scan #(
    .IDENT_MAX (IDENT_MAX),
    .POS_BITS  (POS_BITS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .push_ok (push_ok),
    .push    (push)
  );

  // room for the two tokens one byte may give
  assign push_ok = q_cnt_r <= cst_pkg::QCNT_W'(cst_pkg::QUEUE_DEPTH - 2);
  assign pop     = out_bus.valid && out_bus.ready;

  // output beat from queue head
  assign head                   = q_mem[rd_ptr_r];
  assign out_bus.valid          = q_cnt_r != '0;
  assign out_bus.kind           = head.kind;
  assign out_bus.int_value      = head.int_value;
  assign out_bus.ident_text     = head.ident_text;
  assign out_bus.ident_len      = head.ident_len;
  assign out_bus.ident_overflow = head.ident_overflow;
  assign out_bus.row            = head.row;
  assign out_bus.col            = head.col;
  assign out_bus.last           = head.last;

  // queue storage
  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      q_mem[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      q_mem[wr_ptr_r + cst_pkg::QPTR_W'(1)] <= push.second;
    end
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      q_cnt_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + cst_pkg::QPTR_W'(push.count);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + cst_pkg::QPTR_W'(1);
      end
      q_cnt_r <= q_cnt_r + cst_pkg::QCNT_W'(push.count) - cst_pkg::QCNT_W'(pop);
    end
  end

endmodule

### tb/token_checker.sv
`timescale 1ns / 1ps

module token_checker (
  input  logic clk,
  input  logic rst_n,
  cst_in_if    in_mon,
  cst_out_if   out_mon,
  output int   err_count,
  output int   exp_pending
);

  localparam int                        IDENT_MAX  = cst_pkg::IDENT_MAX_DEF;
  localparam logic [cst_pkg::POS_W-1:0] POS_MAX    = '1;
  localparam logic [7:0]                CH_NEWLINE = 8'h0A;
  localparam logic [7:0]                CH_SPACE   = 8'h20;
  localparam logic [7:0]                CH_UNDER   = 8'h5F;
  localparam logic [7:0]                CH_ZERO    = 8'h30;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_IDENT,
    SCAN_NUMBER
  } scan_t;

  // lexer state as seen from outside
  scan_t                         mode;
  logic [cst_pkg::TEXT_W-1:0]    id_text;
  logic [cst_pkg::LEN_W-1:0]     id_len;
  logic                          id_long;
  logic [cst_pkg::VALUE_W-1:0]   num_acc;
  logic [cst_pkg::POS_W-1:0]     cur_row;
  logic [cst_pkg::POS_W-1:0]     cur_col;
  logic [cst_pkg::POS_W-1:0]     tok_row;
  logic [cst_pkg::POS_W-1:0]     tok_col;

  cst_pkg::result_t pending_tokens[$];
  cst_pkg::result_t beat_tokens[$];
  int               token_no;

  initial err_count = 0;

  task automatic log_error(input string msg);
    $display("token_checker: token %0d: %s", token_no, msg);
    err_count++;
  endtask

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic cst_pkg::kind_t punct_kind(input logic [7:0] c);
    case (c)
      "(":     return cst_pkg::KIND_LPAREN;
      ")":     return cst_pkg::KIND_RPAREN;
      "[":     return cst_pkg::KIND_LBRACK;
      "]":     return cst_pkg::KIND_RBRACK;
      "{":     return cst_pkg::KIND_LBRACE;
      "}":     return cst_pkg::KIND_RBRACE;
      ";":     return cst_pkg::KIND_SEMI;
      default: return cst_pkg::KIND_ERROR;
    endcase
  endfunction

  function automatic logic [cst_pkg::POS_W-1:0] pos_inc(
      input logic [cst_pkg::POS_W-1:0] v);
    return (v == POS_MAX) ? v : v + 1'b1;
  endfunction

  function automatic void add_token(input cst_pkg::kind_t k,
                                    input logic [cst_pkg::VALUE_W-1:0] v,
                                    input logic [cst_pkg::TEXT_W-1:0] t,
                                    input logic [cst_pkg::LEN_W-1:0] n,
                                    input logic ovf,
                                    input logic [cst_pkg::POS_W-1:0] r,
                                    input logic [cst_pkg::POS_W-1:0] c);
    cst_pkg::result_t tok;
    tok.kind           = k;
    tok.int_value      = v;
    tok.ident_text     = t;
    tok.ident_len      = n;
    tok.ident_overflow = ovf;
    tok.row            = r;
    tok.col            = c;
    tok.last           = 1'b0;
    beat_tokens.push_back(tok);
  endfunction

  function automatic void clear_scan();
    mode    = SCAN_IDLE;
    id_text = '0;
    id_len  = '0;
    id_long = 1'b0;
    num_acc = '0;
  endfunction

  function automatic void reset_lexer();
    clear_scan();
    cur_row = cst_pkg::POS_W'(1);
    cur_col = '0;
    tok_row = cst_pkg::POS_W'(1);
    tok_col = '0;
  endfunction

  // close the identifier or number in progress, if any
  function automatic void flush_scan();
    cst_pkg::kind_t k;
    if (mode == SCAN_IDENT) begin
      k = cst_pkg::KIND_IDENT;
      if (!id_long) begin
        if (id_len == 3 && id_text == cst_pkg::TEXT_W'(cst_pkg::KW_INT_TEXT))
          k = cst_pkg::KIND_KW_INT;
        else if (id_len == 6 && id_text == cst_pkg::TEXT_W'(cst_pkg::KW_RETURN_TEXT))
          k = cst_pkg::KIND_KW_RETURN;
      end
      if (k == cst_pkg::KIND_IDENT)
        add_token(k, '0, id_text, id_len, id_long, tok_row, tok_col);
      else
        add_token(k, '0, '0, '0, 1'b0, tok_row, tok_col);
    end else if (mode == SCAN_NUMBER) begin
      add_token(cst_pkg::KIND_NUMBER, num_acc, '0, '0, 1'b0, tok_row, tok_col);
    end
    clear_scan();
  endfunction

  function automatic void ident_push(input logic [7:0] c);
    if (id_len < IDENT_MAX) begin
      id_text[id_len*8 +: 8] = c;
      id_len++;
    end else begin
      id_long = 1'b1;
    end
  endfunction

  // tokens caused by one input beat
  function automatic void lex_beat(input logic [7:0] c, input logic eoi);
    beat_tokens.delete();
    if (eoi) begin
      flush_scan();
      add_token(cst_pkg::KIND_EOF, '0, '0, '0, 1'b0, cur_row, cur_col);
      reset_lexer();
    end else begin
      cur_col = pos_inc(cur_col);
      if (c == CH_NEWLINE) begin
        cur_col = '0;
        cur_row = pos_inc(cur_row);
      end
      if (mode == SCAN_IDENT && (is_alpha(c) || is_digit(c))) begin
        ident_push(c);
      end else if (mode == SCAN_NUMBER && is_digit(c)) begin
        num_acc = num_acc * 32'd10 + cst_pkg::VALUE_W'(c - CH_ZERO);
      end else begin
        flush_scan();
        if (is_alpha(c)) begin
          mode    = SCAN_IDENT;
          tok_row = cur_row;
          tok_col = cur_col;
          ident_push(c);
        end else if (is_digit(c)) begin
          mode    = SCAN_NUMBER;
          tok_row = cur_row;
          tok_col = cur_col;
          num_acc = cst_pkg::VALUE_W'(c - CH_ZERO);
        end else if (!is_blank(c)) begin
          add_token(punct_kind(c), '0, '0, '0, 1'b0, cur_row, cur_col);
        end
      end
    end
    if (beat_tokens.size() > 0) beat_tokens[beat_tokens.size()-1].last = 1'b1;
    foreach (beat_tokens[i]) pending_tokens.push_back(beat_tokens[i]);
  endfunction

  task automatic check_field(input string name, input logic [63:0] got_v,
                             input logic [63:0] want_v);
    if (got_v !== want_v)
      log_error($sformatf("%s is 0x%0h, should be 0x%0h", name, got_v, want_v));
  endtask

  // compare an output beat against the oldest predicted token
  task automatic check_token();
    cst_pkg::result_t want;
    if (pending_tokens.size() == 0) begin
      log_error($sformatf("unexpected token, kind %0d row %0d col %0d",
                          out_mon.kind, out_mon.row, out_mon.col));
    end else begin
      want = pending_tokens.pop_front();
      check_field("kind", out_mon.kind, want.kind);
      check_field("int_value", out_mon.int_value, want.int_value);
      check_field("ident_text", out_mon.ident_text, want.ident_text);
      check_field("ident_len", out_mon.ident_len, want.ident_len);
      check_field("ident_overflow", out_mon.ident_overflow, want.ident_overflow);
      check_field("row", out_mon.row, want.row);
      check_field("col", out_mon.col, want.col);
      check_field("last", out_mon.last, want.last);
    end
    token_no++;
  endtask

  // output beats are checked before the same edge's input beat is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_lexer();
      pending_tokens.delete();
      token_no = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) check_token();
      if (in_mon.valid && in_mon.ready) lex_beat(in_mon.ch, in_mon.end_of_input);
    end
    exp_pending <= pending_tokens.size();
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   err_count;
  int   exp_pending;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   hold_ticket = 0;
  int   hold_seen   = 0;
  int   hold_left   = 0;
  int   beats_sent  = 0;
  int   cycle_count = 0;

  cst_in_if  in_bus ();
  cst_out_if out_bus ();

  c_subset_tokenizer uut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  token_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .err_count   (err_count),
    .exp_pending (exp_pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  // token receiver: random stalls, plus a long hold-off on request
  initial begin
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // one source beat, with random idle cycles in front
  task automatic send_beat(input logic [7:0] c, input logic eoi);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid        <= 1'b1;
    in_bus.ch           <= c;
    in_bus.end_of_input <= eoi;
    do @(posedge clk); while (!in_bus.ready);
    beats_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  // stop offering beats until every predicted token has come out
  task automatic wait_drained();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (exp_pending != 0);
  endtask

  function automatic logic [7:0] ident_char(input bit lead);
    int r;
    r = $urandom_range(lead ? 52 : 62);
    if (r < 26) return 8'(8'h61 + r);
    if (r < 52) return 8'(8'h41 + r - 26);
    if (r == 52) return 8'h5F;
    return 8'(8'h30 + r - 53);
  endfunction

  function automatic logic [7:0] error_char();
    string sym;
    sym = "!#$%&*+,-./:<=>?@^`|~\"'\\";
    case ($urandom_range(3))
      0:       return 8'($urandom_range(8));
      1:       return 8'($urandom_range(31, 14));
      2:       return 8'($urandom_range(255, 127));
      default: return sym[$urandom_range(sym.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0:       return 8'h09;
      1:       return 8'h0A;
      2:       return 8'h0B;
      3:       return 8'h0C;
      4:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic string word_pick();
    case ($urandom_range(7))
      0:       return "int";
      1:       return "return";
      2:       return "in";
      3:       return "intx";
      4:       return "retur";
      5:       return "returns";
      6:       return "INT";
      default: return "int9";
    endcase
  endfunction

  // one lexeme-shaped fragment of source text, or noise
  task automatic send_fragment();
    string punct;
    int    pick;
    int    n;
    punct = "()[]{};";
    pick  = $urandom_range(99);
    if (pick < 22) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(12, 7) : $urandom_range(5, 1);
      for (int i = 0; i < n; i++) send_beat(ident_char(i == 0), 1'b0);
    end else if (pick < 30) begin
      send_text(word_pick());
    end else if (pick < 48) begin
      n = ($urandom_range(3) == 0) ? $urandom_range(12, 8) : $urandom_range(4, 1);
      for (int i = 0; i < n; i++) send_beat(8'(8'h30 + $urandom_range(9)), 1'b0);
    end else if (pick < 68) begin
      send_beat(punct[$urandom_range(6)], 1'b0);
    end else if (pick < 82) begin
      n = $urandom_range(3, 1);
      repeat (n) send_beat(blank_char(), 1'b0);
    end else if (pick < 88) begin
      send_beat(error_char(), 1'b0);
    end else if (pick < 97) begin
      send_beat(8'($urandom_range(255)), 1'b0);
    end else begin
      send_beat(8'($urandom_range(255)), 1'b1);
    end
  endtask

  task automatic run_random(input int count);
    int start;
    start = beats_sent;
    while (beats_sent - start < count) send_fragment();
  endtask

  // stimulus and verdict
  initial begin
    rst_n               = 1'b0;
    in_bus.valid        = 1'b0;
    in_bus.ch           = '0;
    in_bus.end_of_input = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every punctuation, both keywords, number then letter, odd bytes
    send_text("int(return)[7]{x};\n12a");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h41, 1'b1);
    send_beat(8'h3B, 1'b1);
    wait_drained();

    // sender mostly busy, receiver mostly stalled
    tx_idle_pct = 21;
    rx_idle_pct <= 86;
    run_random(400);
    wait_drained();

    // sender mostly idle, receiver mostly ready
    tx_idle_pct = 86;
    rx_idle_pct <= 21;
    run_random(400);
    wait_drained();

    // full rate, with one long receiver hold-off so the input backs up
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_ticket <= hold_ticket + 1;
    run_random(400);
    wait_drained();

    // reset of position by end of input
    send_text("ab(");
    send_beat(8'h00, 1'b1);
    send_text("y;");
    send_beat(8'hFF, 1'b1);
    wait_drained();

    repeat (10) @(posedge clk);
    if (err_count == 0 && exp_pending == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
